/* design/cdt_pkg.sv */
package cdt_pkg;

    localparam int MENU_ENTRIES_DEF = 4;

    // timer modes
    localparam logic [1:0] MODE_SET   = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_MENU  = 2'd2;
    localparam logic [1:0] MODE_ALARM = 2'd3;

    // menu entries
    localparam logic [1:0] MENU_RESUME = 2'd0;
    localparam logic [1:0] MENU_ADJUST = 2'd1;
    localparam logic [1:0] MENU_RESET  = 2'd2;
    localparam logic [1:0] MENU_EXIT   = 2'd3;

    localparam logic [15:0] LOW_TIME_LIMIT = 16'd300;

    // configuration register map
    localparam int         CFG_AW   = 5;
    localparam logic [2:0] REG_STEP = 3'd0;
    localparam logic [2:0] REG_MAX  = 3'd1;
    localparam logic [2:0] REG_TICK = 3'd2;
    localparam logic [2:0] REG_BEEP = 3'd3;
    localparam logic [2:0] REG_ARM  = 3'd4;

    localparam logic [11:0] STEP_RST = 12'd300;
    localparam logic [15:0] MAX_RST  = 16'd10800;
    localparam logic [15:0] TICK_RST = 16'd1000;
    localparam logic [15:0] BEEP_RST = 16'd800;
    localparam logic [15:0] ARM_RST  = 16'd3000;

    typedef struct packed {
        logic [11:0] step_seconds;
        logic [15:0] max_seconds;
        logic [15:0] tick_ms;
        logic [15:0] beep_period_ms;
        logic [15:0] arm_period_ms;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] seconds_left;
        logic [1:0]  cursor;
        logic        low_time;
        logic        arm_move;
        logic        arm_raised;
        logic        beep;
        logic        blink_on;
        logic        exit_request;
    } result_t;

endpackage

/* design/countdown_timer_with_alarm.sv */
// Countdown timer with alarm. Each input beat is one poll (button, encoder
// detents, millisecond clock) and yields exactly one result beat with the mode,
// time left, menu cursor and the alarm pulses. The block takes one poll per
// clock cycle while the result side is not stalled: a poll is held in the input
// register, the mode update is computed from it and written to the result
// register when the poll moves on; a stalled result holds the poll behind it
// in the input register. The rate is set by the update of the timer state,
// which each poll reads and writes. Configuration is written through the APB
// port at byte addresses 4*i and is read back the same way; write it only
// while no poll is in flight.
module countdown_timer_with_alarm #(
    parameter int MENU_ENTRIES = cdt_pkg::MENU_ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cdt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_button_pressed,
    input  logic signed [4:0]          s_rotation,
    input  logic [31:0]                s_now_ms,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_mode,
    output logic [15:0]                m_seconds_left,
    output logic [1:0]                 m_cursor,
    output logic                       m_low_time,
    output logic                       m_arm_move,
    output logic                       m_arm_raised,
    output logic                       m_beep,
    output logic                       m_blink_on,
    output logic                       m_exit_request
);

    cdt_pkg::cfg_t    cfg;
    cdt_pkg::result_t res;
    cdt_pkg::result_t res_reg;

    logic              in_valid_reg, in_valid_next;
    logic              in_press_reg;
    logic signed [4:0] in_rot_reg;
    logic [31:0]       in_now_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              in_take;

    cdt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cdt_step #(
        .MENU_ENTRIES (MENU_ENTRIES)
    ) u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .press   (in_press_reg),
        .rot     (in_rot_reg),
        .now     (in_now_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // the held poll moves on when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_press_reg <= s_button_pressed;
            in_rot_reg   <= s_rotation;
            in_now_reg   <= s_now_ms;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mode         = res_reg.mode;
    assign m_seconds_left = res_reg.seconds_left;
    assign m_cursor       = res_reg.cursor;
    assign m_low_time     = res_reg.low_time;
    assign m_arm_move     = res_reg.arm_move;
    assign m_arm_raised   = res_reg.arm_raised;
    assign m_beep         = res_reg.beep;
    assign m_blink_on     = res_reg.blink_on;
    assign m_exit_request = res_reg.exit_request;

endmodule

/* design/cdt_regs.sv */
module cdt_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [cdt_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output cdt_pkg::cfg_t             cfg
);

    logic [11:0] step_seconds_reg;
    logic [15:0] max_seconds_reg;
    logic [15:0] tick_ms_reg;
    logic [15:0] beep_period_ms_reg;
    logic [15:0] arm_period_ms_reg;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cdt_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_seconds_reg   <= cdt_pkg::STEP_RST;
            max_seconds_reg    <= cdt_pkg::MAX_RST;
            tick_ms_reg        <= cdt_pkg::TICK_RST;
            beep_period_ms_reg <= cdt_pkg::BEEP_RST;
            arm_period_ms_reg  <= cdt_pkg::ARM_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                cdt_pkg::REG_STEP: step_seconds_reg   <= pwdata[11:0];
                cdt_pkg::REG_MAX:  max_seconds_reg    <= pwdata[15:0];
                cdt_pkg::REG_TICK: tick_ms_reg        <= pwdata[15:0];
                cdt_pkg::REG_BEEP: beep_period_ms_reg <= pwdata[15:0];
                cdt_pkg::REG_ARM:  arm_period_ms_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            cdt_pkg::REG_STEP: prdata = {20'd0, step_seconds_reg};
            cdt_pkg::REG_MAX:  prdata = {16'd0, max_seconds_reg};
            cdt_pkg::REG_TICK: prdata = {16'd0, tick_ms_reg};
            cdt_pkg::REG_BEEP: prdata = {16'd0, beep_period_ms_reg};
            cdt_pkg::REG_ARM:  prdata = {16'd0, arm_period_ms_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.step_seconds   = step_seconds_reg;
    assign cfg.max_seconds    = max_seconds_reg;
    assign cfg.tick_ms        = tick_ms_reg;
    assign cfg.beep_period_ms = beep_period_ms_reg;
    assign cfg.arm_period_ms  = arm_period_ms_reg;

endmodule

/* design/cdt_step.sv */
module cdt_step #(
    parameter int MENU_ENTRIES = cdt_pkg::MENU_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               press,
    input  logic signed [4:0]  rot,
    input  logic [31:0]        now,
    input  cdt_pkg::cfg_t      cfg,
    output cdt_pkg::result_t   res
);

    localparam logic signed [6:0] MENU_LAST = 7'(MENU_ENTRIES - 1);

    logic [1:0]  mode_reg, mode_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [31:0] last_event_reg, last_event_next;
    logic [31:0] last_arm_reg, last_arm_next;
    logic        arm_up_next_reg, arm_up_next_next;
    logic        blink_phase_reg, blink_phase_next;
    logic [1:0]  menu_pos_reg, menu_pos_next;

    logic signed [17:0] step_s, rot_s, prod, set_sum, max_s;
    logic [15:0] set_val, dec_val, rem_m1;
    logic [31:0] elapsed_ev, elapsed_arm;
    logic        tick_due, arm_due, beep_due;
    logic signed [6:0] pos_sum;
    logic [1:0]  pos_val;
    logic        arm_pulse, beep_pulse, exit_pulse;

    // setting: remaining + step * rotation, clamped to 0..max
    assign step_s  = {6'd0, cfg.step_seconds};
    assign rot_s   = {{13{rot[4]}}, rot};
    assign prod    = step_s * rot_s;
    assign set_sum = $signed({2'b00, remaining_reg}) + prod;
    assign max_s   = {2'b00, cfg.max_seconds};

    always_comb begin
        if (set_sum > max_s) begin
            set_val = cfg.max_seconds;
        end else if (set_sum < 18'sd0) begin
            set_val = 16'd0;
        end else begin
            set_val = set_sum[15:0];
        end
    end

    // running: remaining - 1 clamped, a zero count stays at zero
    assign rem_m1 = remaining_reg - 16'd1;
    always_comb begin
        if (remaining_reg == 16'd0) begin
            dec_val = 16'd0;
        end else if (rem_m1 > cfg.max_seconds) begin
            dec_val = cfg.max_seconds;
        end else begin
            dec_val = rem_m1;
        end
    end

    // wrap-around elapsed times
    assign elapsed_ev  = now - last_event_reg;
    assign elapsed_arm = now - last_arm_reg;
    assign tick_due    = elapsed_ev >= {16'd0, cfg.tick_ms};
    assign beep_due    = elapsed_ev > {16'd0, cfg.beep_period_ms};
    assign arm_due     = elapsed_arm >= {16'd0, cfg.arm_period_ms};

    assign pos_sum = $signed({5'd0, menu_pos_reg}) + $signed({{2{rot[4]}}, rot});
    always_comb begin
        if (pos_sum > MENU_LAST) begin
            pos_val = MENU_LAST[1:0];
        end else if (pos_sum < 7'sd0) begin
            pos_val = 2'd0;
        end else begin
            pos_val = pos_sum[1:0];
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        remaining_next   = remaining_reg;
        last_event_next  = last_event_reg;
        last_arm_next    = last_arm_reg;
        arm_up_next_next = arm_up_next_reg;
        blink_phase_next = blink_phase_reg;
        menu_pos_next    = menu_pos_reg;
        arm_pulse        = 1'b0;
        beep_pulse       = 1'b0;
        exit_pulse       = 1'b0;
        unique case (mode_reg)
            cdt_pkg::MODE_SET: begin
                if (press) begin
                    mode_next = (remaining_reg == 16'd0) ? cdt_pkg::MODE_MENU
                                                          : cdt_pkg::MODE_RUN;
                end else begin
                    remaining_next = set_val;
                end
            end
            cdt_pkg::MODE_RUN: begin
                if (press) begin
                    mode_next = cdt_pkg::MODE_MENU;
                end else if (tick_due) begin
                    last_event_next = now;
                    remaining_next  = dec_val;
                    if (dec_val == 16'd0) begin
                        mode_next = cdt_pkg::MODE_ALARM;
                    end
                end
            end
            cdt_pkg::MODE_MENU: begin
                menu_pos_next = pos_val;
                if (press) begin
                    mode_next = cdt_pkg::MODE_SET;
                    case (pos_val)
                        cdt_pkg::MENU_RESUME: begin
                            if (remaining_reg != 16'd0) begin
                                mode_next = cdt_pkg::MODE_RUN;
                            end
                        end
                        cdt_pkg::MENU_RESET:  remaining_next = 16'd0;
                        cdt_pkg::MENU_EXIT:   exit_pulse = 1'b1;
                        default: ;
                    endcase
                end
            end
            default: begin
                if (press) begin
                    mode_next = cdt_pkg::MODE_SET;
                end else begin
                    if (arm_due) begin
                        last_arm_next    = now;
                        arm_pulse        = 1'b1;
                        arm_up_next_next = !arm_up_next_reg;
                    end
                    if (beep_due) begin
                        last_event_next  = now;
                        beep_pulse       = 1'b1;
                        blink_phase_next = !blink_phase_reg;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= cdt_pkg::MODE_SET;
            remaining_reg   <= 16'd0;
            last_event_reg  <= 32'd0;
            last_arm_reg    <= 32'd0;
            arm_up_next_reg <= 1'b1;
            blink_phase_reg <= 1'b1;
            menu_pos_reg    <= 2'd0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            remaining_reg   <= remaining_next;
            last_event_reg  <= last_event_next;
            last_arm_reg    <= last_arm_next;
            arm_up_next_reg <= arm_up_next_next;
            blink_phase_reg <= blink_phase_next;
            menu_pos_reg    <= menu_pos_next;
        end
    end

    assign res.mode         = mode_next;
    assign res.seconds_left = remaining_next;
    assign res.cursor       = menu_pos_next;
    assign res.low_time     = (mode_next == cdt_pkg::MODE_RUN) &&
                              (remaining_next <= cdt_pkg::LOW_TIME_LIMIT);
    assign res.arm_move     = arm_pulse;
    assign res.arm_raised   = !arm_up_next_next;
    assign res.beep         = beep_pulse;
    assign res.blink_on     = (mode_next == cdt_pkg::MODE_ALARM) && !blink_phase_next;
    assign res.exit_request = exit_pulse;

endmodule

/* design/cdt_checker.sv */
module cdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_mode,
    input logic [15:0] m_seconds_left,
    input logic        m_low_time,
    input logic        m_arm_move,
    input logic        m_beep,
    input logic        m_blink_on,
    input logic        m_exit_request
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mode) && $stable(m_seconds_left))
        else $error("result beat changed while stalled");

    a_low_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_low_time |->
            (m_mode == cdt_pkg::MODE_RUN) && (m_seconds_left <= cdt_pkg::LOW_TIME_LIMIT))
        else $error("low_time outside running with little time left");

    a_alarm_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_arm_move || m_beep || m_blink_on) |-> m_mode == cdt_pkg::MODE_ALARM)
        else $error("alarm outputs outside alarm mode");

    a_exit_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_exit_request |-> m_mode == cdt_pkg::MODE_SET && !m_arm_move && !m_beep)
        else $error("exit request without return to setting");

    a_alarm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_mode == cdt_pkg::MODE_ALARM |-> m_seconds_left == 16'd0)
        else $error("alarm with time left");

endmodule

bind countdown_timer_with_alarm cdt_checker u_cdt_checker (.*);

/* bench/tb_countdown_timer_with_alarm.sv */
`timescale 1ns / 1ps

module tb_countdown_timer_with_alarm;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_POLLS = 280;
    localparam int NUM_PHASES  = 7;

    typedef enum int {READY_FREE, READY_JITTER, READY_HOLD} ready_style_t;

    // value carries now_ms for a poll and the register data for a write
    typedef struct packed {
        logic              is_cfg;
        logic [2:0]        reg_idx;
        logic              press;
        logic signed [4:0] rot;
        logic [31:0]       value;
        logic              typed;
        cdt_pkg::result_t  res;
    } dir_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [cdt_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0]                pwdata = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_button_pressed = 1'b0;
    logic signed [4:0]          s_rotation = '0;
    logic [31:0]                s_now_ms = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [1:0]                 m_mode;
    logic [15:0]                m_seconds_left;
    logic [1:0]                 m_cursor;
    logic                       m_low_time;
    logic                       m_arm_move;
    logic                       m_arm_raised;
    logic                       m_beep;
    logic                       m_blink_on;
    logic                       m_exit_request;

    countdown_timer_with_alarm DUT (.*);

    always #5 aclk = ~aclk;

    // timer shadow, updated at each accepted poll
    cdt_pkg::cfg_t timer_cfg = '{step_seconds: cdt_pkg::STEP_RST,
                                 max_seconds: cdt_pkg::MAX_RST,
                                 tick_ms: cdt_pkg::TICK_RST,
                                 beep_period_ms: cdt_pkg::BEEP_RST,
                                 arm_period_ms: cdt_pkg::ARM_RST};
    logic [1:0]  tm_mode = cdt_pkg::MODE_SET;
    logic [15:0] tm_left = '0;
    logic [31:0] tm_evt_ms = '0;
    logic [31:0] tm_arm_ms = '0;
    logic        tm_arm_up_next = 1'b1;
    logic        tm_blink_phase = 1'b1;
    logic [1:0]  tm_cursor = '0;

    cdt_pkg::result_t expected_status_q[$];
    int               mismatch_count = 0;
    int               idle_cycles = 0;
    logic             drv_typed = 1'b0;
    cdt_pkg::result_t drv_typed_res = '0;
    int               burst_left = 0;
    logic [31:0]      clk_ms = '0;
    int               ready_left = 0;
    ready_style_t     ready_style = READY_FREE;

    function automatic int clamp_int(int v, int lo, int hi);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v;
    endfunction

    function automatic cdt_pkg::result_t advance_timer(input logic press,
                                                       input logic signed [4:0] rot,
                                                       input logic [31:0] now);
        int               r;
        logic [31:0]      since_evt;
        logic [31:0]      since_arm;
        cdt_pkg::result_t res;
        r = rot;
        since_evt = now - tm_evt_ms;
        since_arm = now - tm_arm_ms;
        res = '0;
        case (tm_mode)
            cdt_pkg::MODE_SET: begin
                if (press) begin
                    tm_mode = (tm_left == 0) ? cdt_pkg::MODE_MENU : cdt_pkg::MODE_RUN;
                end else begin
                    tm_left = 16'(clamp_int(int'(tm_left) + int'(timer_cfg.step_seconds) * r,
                                            0, int'(timer_cfg.max_seconds)));
                end
            end
            cdt_pkg::MODE_RUN: begin
                if (press) begin
                    tm_mode = cdt_pkg::MODE_MENU;
                end else if (since_evt >= 32'(timer_cfg.tick_ms)) begin
                    tm_evt_ms = now;
                    tm_left = 16'(clamp_int(int'(tm_left) - 1, 0, int'(timer_cfg.max_seconds)));
                    if (tm_left == 0) tm_mode = cdt_pkg::MODE_ALARM;
                end
            end
            cdt_pkg::MODE_MENU: begin
                tm_cursor = 2'(clamp_int(int'(tm_cursor) + r, 0,
                                         cdt_pkg::MENU_ENTRIES_DEF - 1));
                if (press) begin
                    case (tm_cursor)
                        cdt_pkg::MENU_RESUME: tm_mode = (tm_left > 0) ? cdt_pkg::MODE_RUN
                                                                      : cdt_pkg::MODE_SET;
                        cdt_pkg::MENU_ADJUST: tm_mode = cdt_pkg::MODE_SET;
                        cdt_pkg::MENU_RESET: begin
                            tm_left = '0;
                            tm_mode = cdt_pkg::MODE_SET;
                        end
                        cdt_pkg::MENU_EXIT: begin
                            res.exit_request = 1'b1;
                            tm_mode = cdt_pkg::MODE_SET;
                        end
                    endcase
                end
            end
            cdt_pkg::MODE_ALARM: begin
                if (press) begin
                    tm_mode = cdt_pkg::MODE_SET;
                end else begin
                    if (since_arm >= 32'(timer_cfg.arm_period_ms)) begin
                        tm_arm_ms = now;
                        res.arm_move = 1'b1;
                        tm_arm_up_next = ~tm_arm_up_next;
                    end
                    if (since_evt > 32'(timer_cfg.beep_period_ms)) begin
                        tm_evt_ms = now;
                        res.beep = 1'b1;
                        tm_blink_phase = ~tm_blink_phase;
                    end
                end
            end
        endcase
        res.mode = tm_mode;
        res.seconds_left = tm_left;
        res.cursor = tm_cursor;
        res.low_time = (tm_mode == cdt_pkg::MODE_RUN) && (tm_left <= cdt_pkg::LOW_TIME_LIMIT);
        res.arm_raised = ~tm_arm_up_next;
        res.blink_on = (tm_mode == cdt_pkg::MODE_ALARM) && !tm_blink_phase;
        return res;
    endfunction

    function automatic int report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got === want) return 0;
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge aclk) begin : result_monitor
        cdt_pkg::result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status_q.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    mismatch_count += report_field("mode", 32'(want.mode), 32'(m_mode));
                    mismatch_count += report_field("seconds_left", 32'(want.seconds_left),
                                                   32'(m_seconds_left));
                    mismatch_count += report_field("cursor", 32'(want.cursor), 32'(m_cursor));
                    mismatch_count += report_field("low_time", 32'(want.low_time),
                                                   32'(m_low_time));
                    mismatch_count += report_field("arm_move", 32'(want.arm_move),
                                                   32'(m_arm_move));
                    mismatch_count += report_field("arm_raised", 32'(want.arm_raised),
                                                   32'(m_arm_raised));
                    mismatch_count += report_field("beep", 32'(want.beep), 32'(m_beep));
                    mismatch_count += report_field("blink_on", 32'(want.blink_on),
                                                   32'(m_blink_on));
                    mismatch_count += report_field("exit_request", 32'(want.exit_request),
                                                   32'(m_exit_request));
                end
            end
            if (s_valid && s_ready) begin
                want = advance_timer(s_button_pressed, s_rotation, s_now_ms);
                expected_status_q.push_back(drv_typed ? drv_typed_res : want);
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side backpressure, independent of the sender
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 2));
            ready_left = (ready_style == READY_HOLD) ? $urandom_range(1, 12)
                                                     : $urandom_range(1, 60);
        end
        ready_left--;
        case (ready_style)
            READY_FREE:   m_ready = 1'b1;
            READY_JITTER: m_ready = ($urandom_range(0, 3) != 0);
            READY_HOLD:   m_ready = 1'b0;
        endcase
    end

    task automatic send_poll(input logic press, input logic signed [4:0] rot,
                             input logic [31:0] now, input logic typed,
                             input cdt_pkg::result_t typed_res);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        burst_left--;
        s_button_pressed = press;
        s_rotation = rot;
        s_now_ms = now;
        drv_typed = typed;
        drv_typed_res = typed_res;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic quiesce;
        s_valid = 1'b0;
        while (expected_status_q.size() != 0) @(negedge aclk);
    endtask

    task automatic program_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] readback;
        readback = (idx == cdt_pkg::REG_STEP) ? {20'd0, val[11:0]} : {16'd0, val[15:0]};
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            cdt_pkg::REG_STEP: timer_cfg.step_seconds = val[11:0];
            cdt_pkg::REG_MAX:  timer_cfg.max_seconds = val[15:0];
            cdt_pkg::REG_TICK: timer_cfg.tick_ms = val[15:0];
            cdt_pkg::REG_BEEP: timer_cfg.beep_period_ms = val[15:0];
            cdt_pkg::REG_ARM:  timer_cfg.arm_period_ms = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== readback) begin
            $error("register %0d readback: expected %0h, actual %0h", idx, readback, prdata);
            mismatch_count++;
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_settings(input cdt_pkg::cfg_t c);
        quiesce();
        program_reg(cdt_pkg::REG_STEP, 32'(c.step_seconds));
        program_reg(cdt_pkg::REG_MAX, 32'(c.max_seconds));
        program_reg(cdt_pkg::REG_TICK, 32'(c.tick_ms));
        program_reg(cdt_pkg::REG_BEEP, 32'(c.beep_period_ms));
        program_reg(cdt_pkg::REG_ARM, 32'(c.arm_period_ms));
    endtask

    // mostly plausible user behavior per mode, with clock stamps aimed at the
    // tick, beep and arm boundaries and a share of wild values
    task automatic drive_random_polls(input int n);
        int          pick;
        int          rot;
        int          full_rot;
        logic        press;
        logic [31:0] now;
        logic [31:0] span;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            span = (tm_mode == cdt_pkg::MODE_ALARM) ? 32'(timer_cfg.beep_period_ms)
                                                    : 32'(timer_cfg.tick_ms);
            if (pick < 6) begin
                now = $urandom();
            end else if (pick < 10) begin
                now = clk_ms + $urandom_range(0, 300000);
            end else if (pick < 30) begin
                case (tm_mode)
                    cdt_pkg::MODE_RUN: now = tm_evt_ms + timer_cfg.tick_ms
                                             - $urandom_range(0, 1);
                    cdt_pkg::MODE_ALARM: begin
                        if ($urandom_range(0, 1) != 0)
                            now = tm_arm_ms + timer_cfg.arm_period_ms - $urandom_range(0, 1);
                        else
                            now = tm_evt_ms + timer_cfg.beep_period_ms + $urandom_range(0, 1);
                    end
                    default: now = clk_ms + $urandom_range(0, 3);
                endcase
            end else begin
                now = clk_ms + $urandom_range(0, 2 * span);
            end
            clk_ms = now;
            full_rot = int'($urandom_range(0, 31)) - 16;
            case (tm_mode)
                cdt_pkg::MODE_SET: begin
                    press = ($urandom_range(0, 99) < ((tm_left != 0) ? 25 : 10));
                    if ($urandom_range(0, 9) == 0) rot = full_rot;
                    else if (tm_left > 40) rot = int'($urandom_range(0, 3)) - 2;
                    else rot = int'($urandom_range(0, 4)) - 1;
                end
                cdt_pkg::MODE_RUN: begin
                    press = ($urandom_range(0, 99) < 3);
                    rot = full_rot;
                end
                cdt_pkg::MODE_MENU: begin
                    press = ($urandom_range(0, 99) < 35);
                    rot = ($urandom_range(0, 1) != 0) ? full_rot : int'($urandom_range(0, 2)) - 1;
                end
                default: begin
                    press = ($urandom_range(0, 99) < 8);
                    rot = full_rot;
                end
            endcase
            if ($urandom_range(0, 19) == 0) begin
                press = 1'($urandom_range(0, 1));
                rot = int'($urandom_range(0, 31)) - 16;
            end
            send_poll(press, 5'(rot), now, 1'b0, '0);
        end
    endtask

    function automatic dir_row_t poll_row(logic press, int rot, logic [31:0] now);
        dir_row_t r;
        r = '0;
        r.press = press;
        r.rot = 5'(rot);
        r.value = now;
        return r;
    endfunction

    // setting mode at time zero, cursor home, no pulses
    function automatic dir_row_t checked_row(int rot, logic [15:0] left);
        dir_row_t r;
        r = poll_row(1'b0, rot, 32'd0);
        r.typed = 1'b1;
        r.res.mode = cdt_pkg::MODE_SET;
        r.res.seconds_left = left;
        return r;
    endfunction

    function automatic dir_row_t write_row(logic [2:0] idx, logic [31:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    initial begin : stimulus
        dir_row_t      tab[$];
        cdt_pkg::cfg_t c;
        tab = {
            checked_row(0, 16'd0),
            checked_row(-16, 16'd0),
            checked_row(15, 16'd4500),
            poll_row(1'b0, 15, 32'd0),
            checked_row(15, 16'd10800),
            poll_row(1'b1, -16, 32'd0),         // start, rotation ignored
            poll_row(1'b0, 0, 32'd1000),        // first tick right at the period
            poll_row(1'b1, 5, 32'd1000),        // pause into the menu
            poll_row(1'b0, 15, 32'd1000),
            poll_row(1'b1, -16, 32'd1000),      // resume
            poll_row(1'b1, 0, 32'd1000),
            poll_row(1'b1, 1, 32'd1000),        // adjust
            poll_row(1'b1, 0, 32'd1000),
            poll_row(1'b1, 0, 32'd1000),
            poll_row(1'b1, 1, 32'd1000),        // reset clears the time
            poll_row(1'b1, 0, 32'd1000),        // press at zero opens the menu
            poll_row(1'b1, -2, 32'd1000),       // resume with nothing left
            write_row(cdt_pkg::REG_STEP, 32'd1),
            poll_row(1'b0, 2, 32'd1000),
            poll_row(1'b1, 0, 32'd1000),
            poll_row(1'b0, 0, 32'hFFFF_FFFF),
            poll_row(1'b0, 0, 32'd998),         // one short of the tick across the wrap
            poll_row(1'b0, 0, 32'd999),         // last second, alarm
            poll_row(1'b0, 0, 32'd3000),        // arm and beep together
            poll_row(1'b1, 0, 32'd3000),
            poll_row(1'b1, 0, 32'd3000),
            poll_row(1'b1, 3, 32'd3000)         // exit
        };

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (tab[i]) begin
            if (tab[i].is_cfg) begin
                quiesce();
                program_reg(tab[i].reg_idx, tab[i].value);
            end else begin
                send_poll(tab[i].press, tab[i].rot, tab[i].value, tab[i].typed, tab[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: c = '{step_seconds: 12'd1, max_seconds: 16'd1, tick_ms: 16'd1,
                         beep_period_ms: 16'd1, arm_period_ms: 16'd1};
                2: c = '{step_seconds: 12'd3600, max_seconds: 16'hFFFF, tick_ms: 16'hFFFF,
                         beep_period_ms: 16'hFFFF, arm_period_ms: 16'hFFFF};
                3: c = '{step_seconds: cdt_pkg::STEP_RST, max_seconds: cdt_pkg::MAX_RST,
                         tick_ms: cdt_pkg::TICK_RST, beep_period_ms: cdt_pkg::BEEP_RST,
                         arm_period_ms: cdt_pkg::ARM_RST};
                5: begin
                    c.step_seconds = 12'($urandom_range(1, 3600));
                    c.max_seconds = 16'($urandom_range(1, 65535));
                    c.tick_ms = 16'($urandom_range(1, 65535));
                    c.beep_period_ms = 16'($urandom_range(1, 65535));
                    c.arm_period_ms = 16'($urandom_range(1, 65535));
                end
                6: c = '{step_seconds: 12'd1, max_seconds: 16'd300, tick_ms: 16'd2,
                         beep_period_ms: 16'd3, arm_period_ms: 16'd5};
                default: begin
                    c.step_seconds = 12'($urandom_range(1, 30));
                    c.max_seconds = 16'($urandom_range(20, 400));
                    c.tick_ms = 16'($urandom_range(1, 100));
                    c.beep_period_ms = 16'($urandom_range(1, 200));
                    c.arm_period_ms = 16'($urandom_range(1, 500));
                end
            endcase
            apply_settings(c);
            drive_random_polls(PHASE_POLLS);
        end

        quiesce();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end

endmodule
